// ===== rtl/crlu_pkg.sv =====
// ----------------------------------------------------------------------------
// crlu_pkg
// Types and constants shared by the condition register logic unit: the
// instruction codes and the transfer structs of the command and result sides.
// ----------------------------------------------------------------------------
package crlu_pkg;

    localparam int unsigned CR_W    = 32;
    localparam int unsigned BIT_W   = 5;
    localparam int unsigned FIELD_W = 3;
    localparam int unsigned MASK_W  = 8;
    localparam int unsigned XER_W   = 4;
    localparam int unsigned NIB_W   = 4;

    // instruction codes, the codes above ACT_MCRXR leave the register alone
    typedef enum logic [3:0] {
        ACT_AND   = 4'd0,
        ACT_ANDC  = 4'd1,
        ACT_EQV   = 4'd2,
        ACT_NAND  = 4'd3,
        ACT_NOR   = 4'd4,
        ACT_OR    = 4'd5,
        ACT_ORC   = 4'd6,
        ACT_XOR   = 4'd7,
        ACT_MCRF  = 4'd8,
        ACT_MTCRF = 4'd9,
        ACT_MFCR  = 4'd10,
        ACT_MCRXR = 4'd11
    } action_t;

    // one instruction
    typedef struct packed {
        action_t              action;
        logic [BIT_W-1:0]     bit_a;
        logic [BIT_W-1:0]     bit_b;
        logic [BIT_W-1:0]     bit_d;
        logic [FIELD_W-1:0]   field_src;
        logic [FIELD_W-1:0]   field_dst;
        logic [MASK_W-1:0]    field_mask;
        logic [CR_W-1:0]      gpr_value;
        logic [XER_W-1:0]     xer_flags;
    } cmd_t;

    // one result
    typedef struct packed {
        logic [CR_W-1:0]      cr_value;
        logic [CR_W-1:0]      gpr_result;
        logic                 gpr_write;
        logic                 xer_clear;
    } rsp_t;

endpackage

// ===== rtl/crlu_exec.sv =====
// ----------------------------------------------------------------------------
// crlu_exec
// Executes one condition register instruction against the current register
// value and forms the next register value and the result.
// ----------------------------------------------------------------------------
module crlu_exec (
    input  crlu_pkg::cmd_t              cmd,
    input  logic [crlu_pkg::CR_W-1:0]   cr,
    output logic [crlu_pkg::CR_W-1:0]   cr_next,
    output crlu_pkg::rsp_t              rsp
);

    logic                              bit_a_val;
    logic                              bit_b_val;
    logic                              bit_r;
    logic [crlu_pkg::BIT_W-1:0]        pos_a;
    logic [crlu_pkg::BIT_W-1:0]        pos_b;
    logic [crlu_pkg::BIT_W-1:0]        pos_d;
    logic [crlu_pkg::FIELD_W-1:0]      nib_src;
    logic [crlu_pkg::FIELD_W-1:0]      nib_dst;
    logic [crlu_pkg::NIB_W-1:0]        src_nib;
    logic [crlu_pkg::CR_W-1:0]         nib_mask;
    logic [crlu_pkg::CR_W-1:0]         bit_cr;
    logic [crlu_pkg::CR_W-1:0]         mcrf_cr;
    logic [crlu_pkg::CR_W-1:0]         mcrxr_cr;

    // bit n counts from the msb, so the value position is the complement
    assign pos_a   = ~cmd.bit_a;
    assign pos_b   = ~cmd.bit_b;
    assign pos_d   = ~cmd.bit_d;
    assign nib_src = ~cmd.field_src;
    assign nib_dst = ~cmd.field_dst;

    assign bit_a_val = cr[pos_a];
    assign bit_b_val = cr[pos_b];
    assign src_nib   = cr[{nib_src, 2'b00} +: crlu_pkg::NIB_W];

    // bit logic function
    always_comb
    begin
        unique case (cmd.action)
            crlu_pkg::ACT_AND:  bit_r = bit_a_val & bit_b_val;
            crlu_pkg::ACT_ANDC: bit_r = bit_a_val & ~bit_b_val;
            crlu_pkg::ACT_EQV:  bit_r = ~(bit_a_val ^ bit_b_val);
            crlu_pkg::ACT_NAND: bit_r = ~(bit_a_val & bit_b_val);
            crlu_pkg::ACT_NOR:  bit_r = ~(bit_a_val | bit_b_val);
            crlu_pkg::ACT_OR:   bit_r = bit_a_val | bit_b_val;
            crlu_pkg::ACT_ORC:  bit_r = bit_a_val | ~bit_b_val;
            default:            bit_r = bit_a_val ^ bit_b_val;
        endcase
    end

    // candidate register values for the bit and field writes
    always_comb
    begin
        bit_cr        = cr;
        bit_cr[pos_d] = bit_r;
        mcrf_cr       = cr;
        mcrf_cr[{nib_dst, 2'b00} +: crlu_pkg::NIB_W] = src_nib;
        mcrxr_cr      = cr;
        mcrxr_cr[{nib_dst, 2'b00} +: crlu_pkg::NIB_W] = cmd.xer_flags;
    end

    // expand the mtcrf nibble mask
    always_comb
    begin
        for (int i = 0; i < crlu_pkg::MASK_W; i++)
        begin
            nib_mask[5'(i * crlu_pkg::NIB_W) +: crlu_pkg::NIB_W] =
                {crlu_pkg::NIB_W{cmd.field_mask[3'(i)]}};
        end
    end

    // select the next register value and the side outputs
    always_comb
    begin
        cr_next        = cr;
        rsp.gpr_result = '0;
        rsp.gpr_write  = 1'b0;
        rsp.xer_clear  = 1'b0;
        unique case (cmd.action)
            crlu_pkg::ACT_AND,
            crlu_pkg::ACT_ANDC,
            crlu_pkg::ACT_EQV,
            crlu_pkg::ACT_NAND,
            crlu_pkg::ACT_NOR,
            crlu_pkg::ACT_OR,
            crlu_pkg::ACT_ORC,
            crlu_pkg::ACT_XOR:   cr_next = bit_cr;
            crlu_pkg::ACT_MCRF:  cr_next = mcrf_cr;
            crlu_pkg::ACT_MTCRF: cr_next = (cr & ~nib_mask) | (cmd.gpr_value & nib_mask);
            crlu_pkg::ACT_MFCR:
            begin
                rsp.gpr_result = cr;
                rsp.gpr_write  = 1'b1;
            end
            crlu_pkg::ACT_MCRXR:
            begin
                cr_next       = mcrxr_cr;
                rsp.xer_clear = 1'b1;
            end
            default:             cr_next = cr;
        endcase
        rsp.cr_value = cr_next;
    end

endmodule

// ===== rtl/condition_register_logic_unit.sv =====
// Path: a command transfer loads the command register; executing it loads
// the result register, from which the result transfer is made.
// Throughput: one command per cycle without rsp_stall; the condition register
// feeds back within the execute cycle, so dependent commands need no spacing.
// Reset: rst_n clears the condition register and both valid flags at once.
// ----------------------------------------------------------------------------
// condition_register_logic_unit
// Condition register unit: command register, execute logic with the
// condition register, and result register with valid/stall transfers.
// ----------------------------------------------------------------------------
module condition_register_logic_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  crlu_pkg::cmd_t  cmd,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output crlu_pkg::rsp_t  rsp
);

    logic                              stage_valid_reg;
    crlu_pkg::cmd_t                    stage_cmd_reg;
    logic [crlu_pkg::CR_W-1:0]         cr_reg;
    logic [crlu_pkg::CR_W-1:0]         cr_next;
    logic                              rsp_valid_reg;
    crlu_pkg::rsp_t                    rsp_reg;
    crlu_pkg::rsp_t                    rsp_next;
    logic                              advance;
    logic                              execute;

    // pipeline control: the result register takes a new value when free or draining
    assign advance   = ~rsp_valid_reg | ~rsp_stall;
    assign execute   = stage_valid_reg & advance;
    assign cmd_stall = stage_valid_reg & ~advance;

    // execute logic
    crlu_exec u_exec (
        .cmd     (stage_cmd_reg),
        .cr      (cr_reg),
        .cr_next (cr_next),
        .rsp     (rsp_next)
    );

    // command register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (!cmd_stall)
        begin
            stage_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_valid && !cmd_stall)
        begin
            stage_cmd_reg <= cmd;
        end
    end

    // condition register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cr_reg <= '0;
        end
        else if (execute)
        begin
            cr_reg <= cr_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= stage_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (execute)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    // a held result always shows the current condition register
    a_rsp_matches_cr: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> rsp_reg.cr_value == cr_reg)
        else $error("result cr_value differs from condition register");

    // mfcr and mcrxr are exclusive
    a_side_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> !(rsp_reg.gpr_write && rsp_reg.xer_clear))
        else $error("gpr_write and xer_clear both set");

    // gpr result is zero unless written
    a_gpr_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp_reg.gpr_write) |-> rsp_reg.gpr_result == '0)
        else $error("gpr_result nonzero without gpr_write");

    // the condition register only moves on an execute
    a_cr_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !execute |=> $stable(cr_reg))
        else $error("condition register changed without execute");

    // the command side stalls only while holding a command
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> stage_valid_reg && rsp_valid_reg)
        else $error("command stall without a held command");
`endif

endmodule
